/* design/sbfe_pkg.sv */
`default_nettype none

package sbfe_pkg;

    // Request codes; code 3 is unused and dropped
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [7:0] FRAME_FLAG = 8'h80;   // start-byte flag, also empty collector
    localparam logic [7:0] LOW7_MASK  = 8'h7F;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] proto;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Result of encoding one request: up to two bytes plus the next state
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
        logic [7:0] collector;
        logic [7:0] parity;
    } t_enc_res;

    // Drop the marker bit and everything below it (lowest set bit is the marker)
    function automatic logic [7:0] flush_bits(input logic [7:0] col);
        logic [7:0] res;
        res = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            if (col[i]) begin
                res = col >> (i + 1);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/sbfe_encode.sv */
`default_nettype none

module sbfe_encode
    import sbfe_pkg::*;
(
    input  wire t_in_item   i_item,
    input  wire logic [7:0] i_collector,
    input  wire logic [7:0] i_parity,
    output t_enc_res        o_res
);

    logic [7:0] hi;
    logic [7:0] grp;
    logic [7:0] par_d;
    logic [7:0] flush;

    always_comb begin
        hi    = {i_item.data_byte[7], i_collector[7:1]};
        grp   = hi >> 1;
        par_d = i_parity ^ i_item.data_byte;
        flush = flush_bits(i_collector);

        o_res.count     = 2'd0;
        o_res.first     = '0;
        o_res.second    = '0;
        o_res.collector = i_collector;
        o_res.parity    = i_parity;

        unique case (i_item.req_type)
            REQ_START: begin
                o_res.count          = 2'd1;
                o_res.first.out_byte = FRAME_FLAG | {4'h0, i_item.proto};
                o_res.first.last     = 1'b1;
                o_res.collector      = FRAME_FLAG;
                o_res.parity         = FRAME_FLAG | {4'h0, i_item.proto};
            end
            REQ_DATA: begin
                o_res.first.out_byte = i_item.data_byte & LOW7_MASK;
                if (hi[0]) begin
                    // seven MSBs gathered: emit group byte
                    o_res.count           = 2'd2;
                    o_res.first.last      = 1'b0;
                    o_res.second.out_byte = grp;
                    o_res.second.last     = 1'b1;
                    o_res.collector       = FRAME_FLAG;
                    o_res.parity          = par_d ^ grp;
                end else begin
                    o_res.count       = 2'd1;
                    o_res.first.last  = 1'b1;
                    o_res.collector   = hi;
                    o_res.parity      = par_d;
                end
            end
            REQ_END: begin
                if (i_collector != FRAME_FLAG) begin
                    o_res.count           = 2'd2;
                    o_res.first.out_byte  = flush;
                    o_res.first.last      = 1'b0;
                    o_res.second.out_byte = (i_parity ^ flush) & LOW7_MASK;
                    o_res.second.last     = 1'b1;
                end else begin
                    o_res.count          = 2'd1;
                    o_res.first.out_byte = i_parity & LOW7_MASK;
                    o_res.first.last     = 1'b1;
                end
            end
            default: begin
                o_res.count = 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/seven_bit_frame_encoder_core.sv */
`default_nettype none

// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_data (t_in_item)
// result    out        o_valid / i_stall   o_data (t_out_item)
//
// A request transfer lands in an input register; once the output buffer can
// take it, it is encoded and its one or two result bytes are loaded into a
// two-slot output buffer. One request per cycle when each yields one byte and
// i_stall is low; one that yields two holds the next until the single output
// port, draining one byte a cycle unless i_stall, sends the second. An unused
// request code is dropped without a result. Reset (i_rst_n low, synchronous)
// empties both stages, clears parity and sets the collector to its empty
// marker. o_stall rises only while the input register holds a request that
// the output buffer cannot take yet.

module seven_bit_frame_encoder_core
    import sbfe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // frame state
    logic [7:0] r_collector;
    logic [7:0] r_parity;

    // output buffer: slot 0 is shown, slot 1 holds a pending second byte
    logic [1:0] r_cnt;
    t_out_item  r_out0;
    t_out_item  r_out1;

    t_enc_res   enc;
    logic       out_xfer;
    logic       buf_free;
    logic       move;

    sbfe_encode u_encode (
        .i_item      (r_in),
        .i_collector (r_collector),
        .i_parity    (r_parity),
        .o_res       (enc)
    );

    assign o_valid  = (r_cnt != 2'd0);
    assign o_data   = r_out0;
    assign out_xfer = o_valid && !i_stall;
    // buffer ends this cycle empty
    assign buf_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_xfer);
    assign move     = r_in_valid && buf_free;
    assign o_stall  = r_in_valid && !move;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // frame state updates when the request is encoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collector <= FRAME_FLAG;
            r_parity    <= 8'h00;
        end else if (move) begin
            r_collector <= enc.collector;
            r_parity    <= enc.parity;
        end
    end

    // output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (move) begin
            r_cnt <= enc.count;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out0 <= enc.first;
            r_out1 <= enc.second;
        end else if (out_xfer) begin
            r_out0 <= r_out1;
        end
    end

    // a pair always ends with the final byte in slot 1
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_out0.last && r_out1.last))
        else $error("two-byte result not marked correctly");

    // a lone byte in the buffer is the final one of its request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_out0.last)
        else $error("single pending byte lacks last");

    // input only stalls behind pending output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output buffer");

    // a start request leaves the collector empty
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && (r_in.req_type == REQ_START)) |=> (r_collector == FRAME_FLAG))
        else $error("collector not reset by start");

endmodule

`default_nettype wire
